// File: rtl/rvex_pkg.sv
// ----------------------------------------------------------------------------
// rvex_pkg: shared types and constants for the RV64I execute subset
// Instruction kinds, the request and result item layouts, and access sizes.
// ----------------------------------------------------------------------------
`default_nettype none

package rvex_pkg;

   // Instruction kinds as the decoder delivers them. Codes 24 to 31 only
   // advance the PC.
   typedef enum logic [4:0] {
      KIND_LUI   = 5'd0,
      KIND_AUIPC = 5'd1,
      KIND_JAL   = 5'd2,
      KIND_JALR  = 5'd3,
      KIND_BEQ   = 5'd4,
      KIND_BNE   = 5'd5,
      KIND_BLT   = 5'd6,
      KIND_BGE   = 5'd7,
      KIND_BLTU  = 5'd8,
      KIND_BGEU  = 5'd9,
      KIND_LB    = 5'd10,
      KIND_LH    = 5'd11,
      KIND_LW    = 5'd12,
      KIND_LD    = 5'd13,
      KIND_LBU   = 5'd14,
      KIND_LHU   = 5'd15,
      KIND_LWU   = 5'd16,
      KIND_SB    = 5'd17,
      KIND_SH    = 5'd18,
      KIND_SW    = 5'd19,
      KIND_SD    = 5'd20,
      KIND_ADDI  = 5'd21,
      KIND_ADDIW = 5'd22,
      KIND_ADDW  = 5'd23,
      KIND_ADV   = 5'd24
   } kind_type;

   // Request sideband: what the item carries.
   localparam logic REQ_EXECUTE     = 1'b0;
   localparam logic REQ_LOAD_RETURN = 1'b1;

   // Memory access sizes.
   localparam logic [1:0] SIZE_BYTE   = 2'd0;
   localparam logic [1:0] SIZE_HALF   = 2'd1;
   localparam logic [1:0] SIZE_WORD   = 2'd2;
   localparam logic [1:0] SIZE_DOUBLE = 2'd3;

   localparam logic [63:0] INSN_BYTES = 64'd4;

   localparam int REQ_DATA_W = 304;
   localparam int RSP_DATA_W = 272;

   // Request payload, first member at the top (packed struct order).
   typedef struct packed {
      logic [63:0] load_data;
      logic [4:0]  dest_reg;
      logic [4:0]  imm_sign_pos;
      logic [31:0] imm_raw;
      logic [63:0] src2_value;
      logic [63:0] src1_value;
      logic [63:0] pc;
      logic [4:0]  instr_kind;
   } req_fields_type;

   // Result payload, 266 bits.
   typedef struct packed {
      logic [63:0] store_data;
      logic [63:0] mem_addr;
      logic [1:0]  mem_size_log2;
      logic        mem_store;
      logic        mem_req;
      logic [63:0] write_value;
      logic [4:0]  write_reg;
      logic        write_en;
      logic [63:0] next_pc;
   } rsp_fields_type;

endpackage

`default_nettype wire

// File: rtl/rv64i_execute_subset.sv
// ----------------------------------------------------------------------------
// rv64i_execute_subset: execute step for an RV64I instruction subset
// Computes next PC, register write-back, load/store requests and load data
// extension for one item per clock while results are taken.
// ----------------------------------------------------------------------------
`default_nettype none

// The block takes one item per clock cycle and returns one result item for
// each. An accepted item is captured in an input register. The execute logic
// (one 64-bit adder per path plus 64-bit compares for branches) works
// combinationally on that register, and the result lands in an output
// register, from which it is offered, once that register has room.
// Both registers advance together whenever the result register is empty or
// being drained. While rsp_tready stays high, an item can be accepted in every
// cycle. When a result waits, the input register still takes one more item.
// After that, req_tready stays low until the waiting result is taken, and the
// stall reaches req_tready in the same cycle as rsp_tready. An execute item
// (tuser 0) sign-extends the immediate from bit imm_sign_pos and produces the
// next PC, with at most one of a register write or a memory request with its
// virtual address, access size and masked store data. A load return item
// (tuser 1) carries the memory read data of an earlier load with the same
// kind and destination; loads write sign- or zero-extended data; each echoes
// pc as next_pc. Kinds 24 to 31 only advance the PC by four. BLT and BGE
// compare as signed 64-bit values, and JALR clears bit 0 of its target.
// Writes to x0 are reported like any other; the register file drops them.
// The block has no state beyond its pipeline registers and no configuration.

module rv64i_execute_subset
   import rvex_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,

   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // Bits from 0 up: instr_kind[4:0], pc[68:5], src1_value[132:69],
   // src2_value[196:133], imm_raw[228:197], imm_sign_pos[233:229],
   // dest_reg[238:234], load_data[302:239], zero pad[303].
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // Bit 0: req_type (0 execute, 1 load return).
   input  wire logic                  req_tuser,

   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // Bits from 0 up: next_pc[63:0], write_en[64], write_reg[69:65],
   // write_value[133:70], mem_req[134], mem_store[135],
   // mem_size_log2[137:136], mem_addr[201:138], store_data[265:202],
   // zero pad[271:266].
   output logic [RSP_DATA_W-1:0]      rsp_tdata
);

   localparam int RSP_FIELDS_W = $bits(rsp_fields_type);

   // Pipeline registers.
   logic           in_valid_ff;
   logic           in_valid_in;
   req_fields_type in_data_ff;
   logic           in_type_ff;
   logic           out_valid_ff;
   logic           out_valid_in;
   rsp_fields_type out_data_ff;
   rsp_fields_type out_data_in;

   logic stage_advance;

   // The result register can take a new result when it is empty or drained
   // this cycle; the input register then hands its item on.
   assign stage_advance = !out_valid_ff || rsp_tready;
   assign req_tready    = !in_valid_ff || stage_advance;

   assign in_valid_in  = req_tready ? req_tvalid : in_valid_ff;
   assign out_valid_in = stage_advance ? in_valid_ff : out_valid_ff;

   // ------------------------------------------------------------------------
   // Execute logic.
   // ------------------------------------------------------------------------
   logic [4:0]  kind;
   logic [63:0] pc;
   logic [63:0] src_a;
   logic [63:0] src_b;
   logic [63:0] imm;
   logic        imm_sign;
   logic [63:0] ld;
   logic [63:0] pc_plus4;
   logic [63:0] pc_plus_imm;
   logic [63:0] a_plus_imm;
   logic [63:0] a_plus_b;
   logic        take;

   assign kind  = in_data_ff.instr_kind;
   assign pc    = in_data_ff.pc;
   assign src_a = in_data_ff.src1_value;
   assign src_b = in_data_ff.src2_value;
   assign ld    = in_data_ff.load_data;

   assign imm_sign = in_data_ff.imm_raw[in_data_ff.imm_sign_pos];

   // Keep imm_raw up to the sign position, fill the rest with the sign bit.
   always_comb begin
      for (int i = 0; i < 64; i++) begin
         if (i < 32 && 5'(i) <= in_data_ff.imm_sign_pos) begin
            imm[i] = in_data_ff.imm_raw[i[4:0]];
         end else begin
            imm[i] = imm_sign;
         end
      end
   end

   assign pc_plus4    = pc + INSN_BYTES;
   assign pc_plus_imm = pc + imm;
   assign a_plus_imm  = src_a + imm;
   assign a_plus_b    = src_a + src_b;

   always_comb begin
      out_data_in = '0;
      take        = 1'b0;
      if (in_type_ff == REQ_LOAD_RETURN) begin
         out_data_in.next_pc = pc;
         unique case (kind) inside
            KIND_LB: begin
               out_data_in.write_en    = 1'b1;
               out_data_in.write_value = {{56{ld[7]}}, ld[7:0]};
            end
            KIND_LH: begin
               out_data_in.write_en    = 1'b1;
               out_data_in.write_value = {{48{ld[15]}}, ld[15:0]};
            end
            KIND_LW: begin
               out_data_in.write_en    = 1'b1;
               out_data_in.write_value = {{32{ld[31]}}, ld[31:0]};
            end
            KIND_LD: begin
               out_data_in.write_en    = 1'b1;
               out_data_in.write_value = ld;
            end
            KIND_LBU: begin
               out_data_in.write_en    = 1'b1;
               out_data_in.write_value = {56'd0, ld[7:0]};
            end
            KIND_LHU: begin
               out_data_in.write_en    = 1'b1;
               out_data_in.write_value = {48'd0, ld[15:0]};
            end
            KIND_LWU: begin
               out_data_in.write_en    = 1'b1;
               out_data_in.write_value = {32'd0, ld[31:0]};
            end
            default: begin
            end
         endcase
      end else begin
         out_data_in.next_pc = pc_plus4;
         unique case (kind) inside
            KIND_LUI: begin
               out_data_in.write_en    = 1'b1;
               out_data_in.write_value = imm;
            end
            KIND_AUIPC: begin
               out_data_in.write_en    = 1'b1;
               out_data_in.write_value = pc_plus_imm;
            end
            KIND_JAL: begin
               out_data_in.write_en    = 1'b1;
               out_data_in.write_value = pc_plus4;
               out_data_in.next_pc     = pc_plus_imm;
            end
            KIND_JALR: begin
               out_data_in.write_en    = 1'b1;
               out_data_in.write_value = pc_plus4;
               out_data_in.next_pc     = {a_plus_imm[63:1], 1'b0};
            end
            KIND_BEQ:  take = (src_a == src_b);
            KIND_BNE:  take = (src_a != src_b);
            KIND_BLT:  take = ($signed(src_a) < $signed(src_b));
            KIND_BGE:  take = !($signed(src_a) < $signed(src_b));
            KIND_BLTU: take = (src_a < src_b);
            KIND_BGEU: take = (src_a >= src_b);
            KIND_LB, KIND_LH, KIND_LW, KIND_LD: begin
               out_data_in.mem_req       = 1'b1;
               out_data_in.mem_addr      = a_plus_imm;
               out_data_in.mem_size_log2 = 2'(kind - KIND_LB);
            end
            KIND_LBU, KIND_LHU, KIND_LWU: begin
               out_data_in.mem_req       = 1'b1;
               out_data_in.mem_addr      = a_plus_imm;
               out_data_in.mem_size_log2 = 2'(kind - KIND_LBU);
            end
            KIND_SB, KIND_SH, KIND_SW, KIND_SD: begin
               out_data_in.mem_req       = 1'b1;
               out_data_in.mem_store     = 1'b1;
               out_data_in.mem_addr      = a_plus_imm;
               out_data_in.mem_size_log2 = 2'(kind - KIND_SB);
               case (2'(kind - KIND_SB))
                  SIZE_BYTE:   out_data_in.store_data = {56'd0, src_b[7:0]};
                  SIZE_HALF:   out_data_in.store_data = {48'd0, src_b[15:0]};
                  SIZE_WORD:   out_data_in.store_data = {32'd0, src_b[31:0]};
                  SIZE_DOUBLE: out_data_in.store_data = src_b;
                  default:     out_data_in.store_data = src_b;
               endcase
            end
            KIND_ADDI: begin
               out_data_in.write_en    = 1'b1;
               out_data_in.write_value = a_plus_imm;
            end
            KIND_ADDIW: begin
               out_data_in.write_en    = 1'b1;
               out_data_in.write_value = {{32{a_plus_imm[31]}}, a_plus_imm[31:0]};
            end
            KIND_ADDW: begin
               out_data_in.write_en    = 1'b1;
               out_data_in.write_value = {{32{a_plus_b[31]}}, a_plus_b[31:0]};
            end
            default: begin
            end
         endcase
         if (take) begin
            out_data_in.next_pc = pc_plus_imm;
         end
      end
      // The destination index is only reported alongside a write.
      out_data_in.write_reg = out_data_in.write_en ? in_data_ff.dest_reg : 5'd0;
   end

   // ------------------------------------------------------------------------
   // Registers.
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready) begin
         in_data_ff <= req_fields_type'(req_tdata[$bits(req_fields_type)-1:0]);
         in_type_ff <= req_tuser;
      end
      if (stage_advance) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W - RSP_FIELDS_W)'(0), out_data_ff};

   // ------------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------------

   // An item in the input register moves to the result register when it
   // has room.
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && stage_advance |=> out_valid_ff)
      else $error("item lost between input and result register");

   // A result never asks for both a register write and a memory access.
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> !(out_data_ff.write_en && out_data_ff.mem_req))
      else $error("write and memory request in one result");

   // Store data appears only for a store (a store is always a memory request).
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_data_ff.mem_store |-> out_data_ff.store_data == 64'd0)
      else $error("store data without a store");

   // A full result register that is not drained keeps the input side busy
   // once the input register is full as well.
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && out_valid_ff && !rsp_tready |-> !req_tready)
      else $error("input accepted with both registers stalled");

endmodule

`default_nettype wire

// File: verif/rv64i_execute_subset_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvex_result_checker: result predictor and comparator for the execute subset
// Watches both item channels, predicts each result from the accepted request
// and compares the results in order, field by field.
// ----------------------------------------------------------------------------

module rvex_result_checker
   import rvex_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   input  wire logic                  req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   input  wire logic                  req_tuser,
   input  wire logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   input  wire logic [RSP_DATA_W-1:0] rsp_tdata,
   output int                         error_count,
   output int                         pending_count
);

   rsp_fields_type execute_outcomes[$];
   rsp_fields_type wanted;
   rsp_fields_type seen;
   int             failures = 0;

   // Keeps bits pos..0 of the value and copies bit pos into all higher bits.
   function automatic logic [63:0] extend_from(input logic [63:0] value, input int pos);
      int shift;
      shift = 63 - pos;
      return $signed(value << shift) >>> shift;
   endfunction

   function automatic rsp_fields_type execute_step(input logic item_type,
                                                   input req_fields_type f);
      rsp_fields_type r;
      logic [63:0]    imm;
      logic [63:0]    base_sum;
      logic           taken;
      kind_type       kind;
      r        = '0;
      imm      = extend_from({32'd0, f.imm_raw}, int'(f.imm_sign_pos));
      base_sum = f.src1_value + imm;
      taken    = 1'b0;
      kind     = kind_type'(f.instr_kind);
      r.next_pc = f.pc + INSN_BYTES;
      if (item_type == REQ_LOAD_RETURN) begin
         r.next_pc = f.pc;
         r.write_en = 1'b1;
         case (kind)
            KIND_LB:  r.write_value = extend_from(f.load_data, 7);
            KIND_LH:  r.write_value = extend_from(f.load_data, 15);
            KIND_LW:  r.write_value = extend_from(f.load_data, 31);
            KIND_LD:  r.write_value = f.load_data;
            KIND_LBU: r.write_value = {56'd0, f.load_data[7:0]};
            KIND_LHU: r.write_value = {48'd0, f.load_data[15:0]};
            KIND_LWU: r.write_value = {32'd0, f.load_data[31:0]};
            default:  r.write_en = 1'b0;
         endcase
      end else begin
         case (kind)
            KIND_LUI: begin
               r.write_en = 1'b1;
               r.write_value = imm;
            end
            KIND_AUIPC: begin
               r.write_en = 1'b1;
               r.write_value = f.pc + imm;
            end
            KIND_JAL: begin
               r.write_en = 1'b1;
               r.write_value = f.pc + INSN_BYTES;
               r.next_pc = f.pc + imm;
            end
            KIND_JALR: begin
               r.write_en = 1'b1;
               r.write_value = f.pc + INSN_BYTES;
               r.next_pc = {base_sum[63:1], 1'b0};
            end
            KIND_BEQ:  taken = f.src1_value == f.src2_value;
            KIND_BNE:  taken = f.src1_value != f.src2_value;
            KIND_BLT:  taken = $signed(f.src1_value) < $signed(f.src2_value);
            KIND_BGE:  taken = $signed(f.src1_value) >= $signed(f.src2_value);
            KIND_BLTU: taken = f.src1_value < f.src2_value;
            KIND_BGEU: taken = f.src1_value >= f.src2_value;
            KIND_LB, KIND_LH, KIND_LW, KIND_LD, KIND_LBU, KIND_LHU, KIND_LWU: begin
               r.mem_req = 1'b1;
               r.mem_addr = base_sum;
               case (kind)
                  KIND_LB, KIND_LBU: r.mem_size_log2 = SIZE_BYTE;
                  KIND_LH, KIND_LHU: r.mem_size_log2 = SIZE_HALF;
                  KIND_LW, KIND_LWU: r.mem_size_log2 = SIZE_WORD;
                  default:           r.mem_size_log2 = SIZE_DOUBLE;
               endcase
            end
            KIND_SB, KIND_SH, KIND_SW, KIND_SD: begin
               r.mem_req = 1'b1;
               r.mem_store = 1'b1;
               r.mem_addr = base_sum;
               case (kind)
                  KIND_SB: begin
                     r.mem_size_log2 = SIZE_BYTE;
                     r.store_data = {56'd0, f.src2_value[7:0]};
                  end
                  KIND_SH: begin
                     r.mem_size_log2 = SIZE_HALF;
                     r.store_data = {48'd0, f.src2_value[15:0]};
                  end
                  KIND_SW: begin
                     r.mem_size_log2 = SIZE_WORD;
                     r.store_data = {32'd0, f.src2_value[31:0]};
                  end
                  default: begin
                     r.mem_size_log2 = SIZE_DOUBLE;
                     r.store_data = f.src2_value;
                  end
               endcase
            end
            KIND_ADDI: begin
               r.write_en = 1'b1;
               r.write_value = base_sum;
            end
            KIND_ADDIW: begin
               r.write_en = 1'b1;
               r.write_value = extend_from({32'd0, base_sum[31:0]}, 31);
            end
            KIND_ADDW: begin
               r.write_en = 1'b1;
               r.write_value = extend_from({32'd0, f.src1_value[31:0] + f.src2_value[31:0]}, 31);
            end
            default: ;
         endcase
         if (taken) begin
            r.next_pc = f.pc + imm;
         end
      end
      r.write_reg = r.write_en ? f.dest_reg : 5'd0;
      return r;
   endfunction

   task automatic compare_field(input string field_name, input logic [63:0] predicted,
                                input logic [63:0] observed);
      if (predicted !== observed) begin
         $error("%s mismatch: expected 0x%0h, got 0x%0h", field_name, predicted, observed);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            execute_outcomes.push_back(execute_step(req_tuser,
               req_fields_type'(req_tdata[$bits(req_fields_type)-1:0])));
         end
         if (rsp_tvalid && rsp_tready) begin
            if (execute_outcomes.size() == 0) begin
               $error("result item arrived with no request outstanding");
               failures++;
            end else begin
               wanted = execute_outcomes.pop_front();
               seen = rsp_fields_type'(rsp_tdata[$bits(rsp_fields_type)-1:0]);
               compare_field("next_pc", wanted.next_pc, seen.next_pc);
               compare_field("write_en", 64'(wanted.write_en), 64'(seen.write_en));
               compare_field("write_reg", 64'(wanted.write_reg), 64'(seen.write_reg));
               compare_field("write_value", wanted.write_value, seen.write_value);
               compare_field("mem_req", 64'(wanted.mem_req), 64'(seen.mem_req));
               compare_field("mem_store", 64'(wanted.mem_store), 64'(seen.mem_store));
               compare_field("mem_size_log2", 64'(wanted.mem_size_log2),
                             64'(seen.mem_size_log2));
               compare_field("mem_addr", wanted.mem_addr, seen.mem_addr);
               compare_field("store_data", wanted.store_data, seen.store_data);
            end
         end
      end
      pending_count <= execute_outcomes.size();
      error_count <= failures;
   end

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the RV64I execute subset
// Drives directed and random instruction and load return items with random
// idle bursts on both channels; a checker beside the block predicts and
// compares every result.
// ----------------------------------------------------------------------------

module tb
   import rvex_pkg::*;
();

   // Kind code at the top of the range; like every code past the advance
   // kind it only moves the PC on.
   localparam logic [4:0] KIND_CODE_TOP = 5'd31;
   localparam int RANDOM_ITEMS = 1120;
   // Items at the end of the run that go without any idling.
   localparam int QUIET_TAIL = 150;
   // Index of the random item before which the sender drains the block.
   localparam int DRAIN_POINT = 500;
   localparam int CYCLE_LIMIT = 400000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tuser = REQ_EXECUTE;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   int                    error_count;
   int                    pending_count;
   int                    cycle_count = 0;
   // Shared switch for the idle bursts of both channels.
   bit                    idle_enabled = 1'b0;

   rv64i_execute_subset i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   rvex_result_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // A hung handshake must not run forever.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // The result side accepts in runs of random length. While idling is on,
   // each run is followed by a stall.
   initial begin : result_ready
      int run_cycles;
      forever begin
         run_cycles = $urandom_range(1, 12);
         rsp_tready <= 1'b1;
         repeat (run_cycles) @(posedge clock);
         if (idle_enabled) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clock);
         end
      end
   end

   function automatic req_fields_type make_fields(
      input logic [4:0]  kind,
      input logic [63:0] pc,
      input logic [63:0] src1,
      input logic [63:0] src2,
      input logic [31:0] imm,
      input logic [4:0]  sign_pos,
      input logic [4:0]  dest,
      input logic [63:0] read_data);
      req_fields_type f;
      f.instr_kind   = kind;
      f.pc           = pc;
      f.src1_value   = src1;
      f.src2_value   = src2;
      f.imm_raw      = imm;
      f.imm_sign_pos = sign_pos;
      f.dest_reg     = dest;
      f.load_data    = read_data;
      return f;
   endfunction

   // Operand values lean toward the corners where adders and compares break.
   function automatic logic [63:0] pick_operand();
      case ($urandom_range(0, 7))
         0:       return 64'd0;
         1:       return '1;
         2:       return 64'h8000_0000_0000_0000;
         3:       return 64'h7FFF_FFFF_FFFF_FFFF;
         4:       return 64'($urandom_range(0, 255));
         5:       return -64'($urandom_range(1, 255));
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic logic is_load_kind(input logic [4:0] kind);
      return kind >= KIND_LB && kind <= KIND_LWU;
   endfunction

   // Sends one item and returns once it has been accepted. While idling is
   // on, a random burst of idle cycles may come first. Except to drain, the valid
   // line is only dropped here, never at the same edge where it is raised again.
   task automatic send_item(input logic item_type, input req_fields_type f);
      if (idle_enabled && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= item_type;
      req_tdata  <= {{(REQ_DATA_W - $bits(req_fields_type)){1'b0}}, f};
      do @(posedge clock); while (!req_tready);
   endtask

   // Random item: mostly instructions of the kinds LUI to ADDW, some codes
   // from the advance kind up, and load returns that are usually for loads.
   task automatic make_random_item(output logic item_type, output req_fields_type f);
      logic [4:0] kind;
      logic [4:0] sign_pos;
      logic [63:0] src1;
      logic [63:0] src2;
      if ($urandom_range(0, 99) < 12) begin
         item_type = REQ_LOAD_RETURN;
         kind = ($urandom_range(0, 4) != 0) ? 5'($urandom_range(KIND_LB, KIND_LWU))
                                            : 5'($urandom_range(0, 31));
      end else begin
         item_type = REQ_EXECUTE;
         kind = ($urandom_range(0, 9) != 0) ? 5'($urandom_range(KIND_LUI, KIND_ADDW))
                                            : 5'($urandom_range(KIND_ADV, KIND_CODE_TOP));
      end
      // Real encodings put the sign at bit 11, 12, 20 or 31.
      case ($urandom_range(0, 5))
         0:       sign_pos = 5'd11;
         1:       sign_pos = 5'd12;
         2:       sign_pos = 5'd20;
         3:       sign_pos = 5'd31;
         default: sign_pos = 5'($urandom_range(0, 31));
      endcase
      src1 = pick_operand();
      src2 = pick_operand();
      // Branches need equal and neighboring operands to hit both outcomes.
      if (kind >= KIND_BEQ && kind <= KIND_BGEU) begin
         case ($urandom_range(0, 3))
            0:       src2 = src1;
            1:       src2 = src1 + 64'd1;
            default: ;
         endcase
      end
      f = make_fields(kind, pick_operand(), src1, src2, $urandom, sign_pos,
                      5'($urandom_range(0, 31)), pick_operand());
   endtask

   task automatic drain_block();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   initial begin : stimulus
      req_fields_type f;
      logic           item_type;
      int             k;
      int             n;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed items: every instruction kind once, with operands at the
      // corners of the sign extension, the wrapping sums and the compares.
      send_item(REQ_EXECUTE, make_fields(KIND_LUI, 64'd0, '0, '0,
                                         32'hFFFF_F000, 5'd31, 5'd31, '0));
      send_item(REQ_EXECUTE, make_fields(KIND_AUIPC, '1, '0, '0,
                                         32'h0000_1000, 5'd31, 5'd1, '0));
      send_item(REQ_EXECUTE, make_fields(KIND_JAL, 64'h1000, '0, '0,
                                         32'h001F_FFFE, 5'd20, 5'd0, '0));
      // The jump target of all ones plus two is odd, so bit 0 must be cleared.
      send_item(REQ_EXECUTE, make_fields(KIND_JALR, 64'h2000, '1, '0,
                                         32'h0000_0002, 5'd11, 5'd5, '0));
      send_item(REQ_EXECUTE, make_fields(KIND_BEQ, 64'h3000, 64'h1234, 64'h1234,
                                         32'h0000_0FF0, 5'd11, 5'd0, '0));
      // Sign at bit 0 with that bit clear leaves an immediate of zero.
      send_item(REQ_EXECUTE, make_fields(KIND_BNE, 64'h3000, 64'd0, 64'd1,
                                         32'hFFFF_FFFE, 5'd0, 5'd0, '0));
      // Minus one against one: the signed compares disagree with the
      // unsigned ones here.
      send_item(REQ_EXECUTE, make_fields(KIND_BLT, 64'h4000, '1, 64'd1,
                                         32'h0000_0010, 5'd12, 5'd0, '0));
      send_item(REQ_EXECUTE, make_fields(KIND_BGE, 64'h4000, '1, 64'd1,
                                         32'h0000_0010, 5'd12, 5'd0, '0));
      send_item(REQ_EXECUTE, make_fields(KIND_BLTU, 64'h4000, '1, 64'd1,
                                         32'h0000_0010, 5'd12, 5'd0, '0));
      send_item(REQ_EXECUTE, make_fields(KIND_BGEU, 64'h4000, '1, 64'd1,
                                         32'hFFFF_FFFF, 5'd31, 5'd0, '0));
      // Each load issues its access, then its data returns with the sign bit
      // of every access size set.
      for (k = KIND_LB; k <= KIND_LWU; k++) begin
         f = make_fields(5'(k), 64'h5000, 64'h8000_0000_0000_0000, '0,
                         32'h0000_0FFF, 5'd11, 5'(k), 64'hF0F0_F0F0_8000_8080);
         send_item(REQ_EXECUTE, f);
         send_item(REQ_LOAD_RETURN, f);
      end
      for (k = KIND_SB; k <= KIND_SD; k++) begin
         send_item(REQ_EXECUTE, make_fields(5'(k), 64'h6000, 64'h1000, '1,
                                            32'h0000_07FF, 5'd11, 5'd0, '0));
      end
      send_item(REQ_EXECUTE, make_fields(KIND_ADDI, 64'h7000, 64'h7FFF_FFFF_FFFF_FFFF, '0,
                                         32'h0000_0001, 5'd31, 5'd2, '0));
      send_item(REQ_EXECUTE, make_fields(KIND_ADDIW, 64'h7000, 64'h7FFF_FFFF, '0,
                                         32'h0000_0001, 5'd11, 5'd3, '0));
      send_item(REQ_EXECUTE, make_fields(KIND_ADDW, 64'h7000, 64'h7FFF_FFFF, 64'd1,
                                         32'd0, 5'd0, 5'd4, '0));
      // The advance kind and the top code only advance the PC.
      send_item(REQ_EXECUTE, make_fields(KIND_ADV, '1, '1, '1,
                                         '1, 5'd31, 5'd31, '1));
      send_item(REQ_EXECUTE, make_fields(KIND_CODE_TOP, 64'h8000, '1, '1,
                                         '1, 5'd31, 5'd31, '1));
      // A load return for a kind that is not a load must change nothing.
      send_item(REQ_LOAD_RETURN, make_fields(KIND_ADDI, 64'h9000, '1, '1,
                                             '1, 5'd31, 5'd9, '1));

      // Random part. Idling alternates between stretches with and without
      // bursts, and the tail of the run has none. A load is usually followed
      // by its own load return, as a real memory system would deliver it.
      n = 0;
      while (n < RANDOM_ITEMS) begin
         idle_enabled = (n < RANDOM_ITEMS - QUIET_TAIL) && ((n % 200) >= 40);
         if (n >= DRAIN_POINT && n < DRAIN_POINT + 2 && pending_count >= 0) begin
            // Let the pipeline empty out completely once mid-run.
            if (n == DRAIN_POINT || n == DRAIN_POINT + 1) begin
               drain_block();
               n = DRAIN_POINT + 2;
            end
         end
         make_random_item(item_type, f);
         send_item(item_type, f);
         n++;
         if (item_type == REQ_EXECUTE && is_load_kind(f.instr_kind) &&
             $urandom_range(0, 3) != 0) begin
            f.load_data = pick_operand();
            send_item(REQ_LOAD_RETURN, f);
            n++;
         end
      end
      idle_enabled = 1'b0;

      // Wait for every result, then keep the clock running to catch strays.
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      if (error_count == 0 && pending_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// File: filelist.f
rtl/rvex_pkg.sv
rtl/rv64i_execute_subset.sv
verif/rv64i_execute_subset_checker.sv
verif/tb.sv
